@@ rtl/flp_pkg.sv @@
// ----------------------------------------------------------------------------
// Flow profile loader/player package
// Shared constants, reset defaults and token parser phase codes.
// ----------------------------------------------------------------------------
`default_nettype none

package flp_pkg;

  // Default table depth and register reset
  localparam int unsigned   ProfilePointsDef = 50;
  localparam logic [15:0]   StepTicksRst     = 16'd40;

  // Serial characters
  localparam logic [7:0] CharLt    = 8'h3C;  // '<'
  localparam logic [7:0] CharGt    = 8'h3E;  // '>'
  localparam logic [7:0] CharComma = 8'h2C;  // ','
  localparam logic [7:0] CharPlus  = 8'h2B;  // '+'
  localparam logic [7:0] CharMinus = 8'h2D;  // '-'
  localparam logic [7:0] CharZero  = 8'h30;  // '0'
  localparam logic [7:0] CharNine  = 8'h39;  // '9'
  localparam logic [7:0] CharSpace = 8'h20;  // ' '
  localparam logic [7:0] CharTab   = 8'h09;  // first of TAB..CR
  localparam logic [7:0] CharCr    = 8'h0D;  // last of TAB..CR

  // Request kinds
  localparam logic ReqByte = 1'b0;
  localparam logic ReqTick = 1'b1;

  // Q30 fixed point constants for the reset sine profile
  localparam logic [63:0] PiQ30  = 64'd3373259426;
  localparam logic [63:0] OneQ30 = 64'd1 << 30;
  localparam logic [63:0] HalfQ30 = 64'd1 << 29;

  // Token parser phases
  typedef enum logic [3:0] {
    PH_SKIP   = 4'b0001,  // skipping leading whitespace
    PH_SIGN   = 4'b0010,  // sign seen
    PH_DIGITS = 4'b0100,  // accumulating digits
    PH_IGNORE = 4'b1000   // rest of token ignored
  } tok_phase_e;

endpackage

`default_nettype wire

@@ rtl/flow_profile_loader_player.sv @@
// ----------------------------------------------------------------------------
// Flow profile loader/player
// Plays a duty table on millisecond ticks and reloads it from serial text.
// ----------------------------------------------------------------------------
// Pipeline: each input word moves through the read stage, then the result register.
// Throughput: one input word per cycle unless the result register stalls; the
//   table memory's registered read port sets the extra stage ahead of the result register.
// Reset: all control state clears at once and the table reads as the half-wave
//   sine profile through per-entry valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module flow_profile_loader_player #(
  parameter int unsigned PROFILE_POINTS = flp_pkg::ProfilePointsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: step_ticks
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  // input words
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        req_type_i,
  input  wire logic [7:0]  rx_byte_i,
  // result words
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       motor_duty_o,
  output logic             duty_changed_o,
  output logic             receiving_o,
  output logic             profile_loaded_o
);

  import flp_pkg::*;

  // Table address width and write index width (write index saturates at depth)
  localparam int unsigned AddrW = (PROFILE_POINTS > 1) ? $clog2(PROFILE_POINTS) : 1;
  localparam int unsigned WidxW = $clog2(PROFILE_POINTS + 1);

  // --------------------------------------------------------------------------
  // Reset profile: round(255 * max(0, sin(2*pi*i/N))) in Q30, worked out at
  // elaboration per entry. A short Taylor/Horner series gives the sine.
  // --------------------------------------------------------------------------
  logic [7:0] sine_rom [PROFILE_POINTS];

  for (genvar gi = 0; gi < PROFILE_POINTS; gi++) begin : g_sine
    localparam int unsigned TwoI = 2 * gi;
    localparam int unsigned AngN = (TwoI >= PROFILE_POINTS) ? 0 :
        (((PROFILE_POINTS - TwoI) < TwoI) ? (PROFILE_POINTS - TwoI) : TwoI);
    localparam logic [63:0] X    = (PiQ30 * 64'(AngN)) / 64'(PROFILE_POINTS);
    localparam logic [63:0] X2   = (X * X) >> 30;
    localparam logic [63:0] Acc1 = OneQ30 - (((X2 * OneQ30) >> 30) / 156);
    localparam logic [63:0] Acc2 = OneQ30 - (((X2 * Acc1) >> 30) / 110);
    localparam logic [63:0] Acc3 = OneQ30 - (((X2 * Acc2) >> 30) / 72);
    localparam logic [63:0] Acc4 = OneQ30 - (((X2 * Acc3) >> 30) / 42);
    localparam logic [63:0] Acc5 = OneQ30 - (((X2 * Acc4) >> 30) / 20);
    localparam logic [63:0] Acc6 = OneQ30 - (((X2 * Acc5) >> 30) / 6);
    localparam logic [63:0] Sin  = (X * Acc6) >> 30;
    localparam logic [63:0] Rnd  = (Sin * 255 + HalfQ30) >> 30;
    localparam logic [7:0]  Val  = (TwoI >= PROFILE_POINTS) ? 8'd0 :
                                   ((Rnd > 255) ? 8'd255 : Rnd[7:0]);
    assign sine_rom[gi] = Val;
  end

  // --------------------------------------------------------------------------
  // Handshake and pipeline control
  // --------------------------------------------------------------------------
  logic s1_valid_q;
  logic out_valid_q;
  logic s1_adv;
  logic in_fire;

  // The read stage moves on when the result register is empty or draining
  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  logic [15:0]       step_q;
  logic [AddrW-1:0]  play_q, play_d;
  logic [15:0]       tick_q, tick_d;
  logic              recv_q, recv_d;
  logic [WidxW-1:0]  widx_q, widx_d;
  logic [7:0]        tval_q, tval_d;
  logic              topen_q, topen_d;
  logic              tneg_q, tneg_d;
  tok_phase_e        phase_q, phase_d;

  // Table memory ports and per-word flags
  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [AddrW-1:0]  rd_addr;
  logic              changed;
  logic              loaded;

  // Character classes
  logic       is_digit;
  logic       is_space;
  logic [7:0] digit;
  logic [7:0] tok_result;
  logic       fin_ok;
  logic       tick_wrap;
  logic [AddrW:0] play_inc;

  assign is_digit   = (rx_byte_i >= CharZero) && (rx_byte_i <= CharNine);
  assign is_space   = (rx_byte_i == CharSpace) ||
                      ((rx_byte_i >= CharTab) && (rx_byte_i <= CharCr));
  assign digit      = rx_byte_i - CharZero;
  assign tok_result = tneg_q ? (8'd0 - tval_q) : tval_q;
  // A token is stored only if it saw a character and the table has room
  assign fin_ok     = topen_q && (widx_q < WidxW'(PROFILE_POINTS));
  assign tick_wrap  = ({1'b0, tick_q} + 17'd1) >= {1'b0, step_q};
  assign play_inc   = {1'b0, play_q} + {{AddrW{1'b0}}, 1'b1};

  assign wr_addr = widx_q[AddrW-1:0];
  assign wr_data = tok_result;

  always_comb begin
    play_d  = play_q;
    tick_d  = tick_q;
    recv_d  = recv_q;
    widx_d  = widx_q;
    tval_d  = tval_q;
    topen_d = topen_q;
    tneg_d  = tneg_q;
    phase_d = phase_q;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    rd_addr = '0;
    changed = 1'b0;
    loaded  = 1'b0;

    if (in_fire) begin
      if (req_type_i == ReqTick) begin
        // Ticks advance playback only in play mode
        if (!recv_q) begin
          if (tick_wrap) begin
            tick_d  = '0;
            play_d  = (play_inc >= (AddrW + 1)'(PROFILE_POINTS)) ? '0
                                                                 : play_inc[AddrW-1:0];
            rd_en   = 1'b1;
            rd_addr = play_d;
            changed = 1'b1;
          end else begin
            tick_d = tick_q + 16'd1;
          end
        end
      end else if (!recv_q) begin
        // In play mode only '<' matters: open a fresh load
        if (rx_byte_i == CharLt) begin
          recv_d  = 1'b1;
          widx_d  = '0;
          tval_d  = '0;
          topen_d = 1'b0;
          tneg_d  = 1'b0;
          phase_d = PH_SKIP;
        end
      end else if (rx_byte_i == CharGt || rx_byte_i == CharComma) begin
        // Close the current token
        if (fin_ok) begin
          wr_en  = 1'b1;
          widx_d = widx_q + WidxW'(1);
        end
        tval_d  = '0;
        topen_d = 1'b0;
        tneg_d  = 1'b0;
        phase_d = PH_SKIP;
        if (rx_byte_i == CharGt) begin
          // End of profile: restart playback at entry 0
          recv_d  = 1'b0;
          play_d  = '0;
          tick_d  = '0;
          rd_en   = 1'b1;
          rd_addr = '0;
          changed = 1'b1;
          loaded  = 1'b1;
        end
      end else begin
        topen_d = 1'b1;
        unique case (phase_q)
          PH_SKIP: begin
            if (is_space) begin
              phase_d = PH_SKIP;
            end else if (rx_byte_i == CharPlus || rx_byte_i == CharMinus) begin
              tneg_d  = (rx_byte_i == CharMinus);
              phase_d = PH_SIGN;
            end else if (is_digit) begin
              tval_d  = digit;
              phase_d = PH_DIGITS;
            end else begin
              phase_d = PH_IGNORE;
            end
          end
          PH_SIGN: begin
            if (is_digit) begin
              tval_d  = digit;
              phase_d = PH_DIGITS;
            end else begin
              phase_d = PH_IGNORE;
            end
          end
          PH_DIGITS: begin
            // value * 10 + digit, kept modulo 256
            if (is_digit) begin
              tval_d = {tval_q[4:0], 3'b000} + {tval_q[6:0], 1'b0} + digit;
            end else begin
              phase_d = PH_IGNORE;
            end
          end
          PH_IGNORE: begin
            phase_d = PH_IGNORE;
          end
          default: begin
            phase_d = PH_IGNORE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= StepTicksRst;
      play_q  <= '0;
      tick_q  <= '0;
      recv_q  <= 1'b0;
      widx_q  <= '0;
      tval_q  <= '0;
      topen_q <= 1'b0;
      tneg_q  <= 1'b0;
      phase_q <= PH_SKIP;
    end else begin
      if (cfg_we_i) begin
        step_q <= cfg_wdata_i;
      end
      play_q  <= play_d;
      tick_q  <= tick_d;
      recv_q  <= recv_d;
      widx_q  <= widx_d;
      tval_q  <= tval_d;
      topen_q <= topen_d;
      tneg_q  <= tneg_d;
      phase_q <= phase_d;
    end
  end

  // --------------------------------------------------------------------------
  // Profile table: one write port, one registered read port. Entries not yet
  // written read as the sine profile.
  // --------------------------------------------------------------------------
  logic [7:0]                mem [PROFILE_POINTS];
  logic [7:0]                mem_rd_q;
  logic [PROFILE_POINTS-1:0] written_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      mem_rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (wr_en) begin
      written_q[wr_addr] <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Read stage: hold the flags of the word whose table read is in flight
  // --------------------------------------------------------------------------
  logic             s1_changed_q;
  logic             s1_recv_q;
  logic             s1_loaded_q;
  logic [AddrW-1:0] s1_addr_q;
  logic             s1_written_q;
  logic             s1_byp_q;
  logic [7:0]       s1_byp_data_q;
  logic [7:0]       s1_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_changed_q  <= changed;
      s1_recv_q     <= recv_d;
      s1_loaded_q   <= loaded;
      s1_addr_q     <= rd_addr;
      s1_written_q  <= written_q[rd_addr];
      // '>' may store entry 0 in the same cycle that it reads it: forward
      s1_byp_q      <= wr_en && (wr_addr == rd_addr);
      s1_byp_data_q <= wr_data;
    end
  end

  assign s1_entry = s1_byp_q     ? s1_byp_data_q :
                    s1_written_q ? mem_rd_q      : sine_rom[s1_addr_q];

  // --------------------------------------------------------------------------
  // Result register; the motor duty lives here and updates in word order
  // --------------------------------------------------------------------------
  logic [7:0] duty_q;
  logic       changed_q;
  logic       recv_out_q;
  logic       loaded_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      duty_q      <= '0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q && s1_changed_q) begin
        duty_q <= s1_entry;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      changed_q  <= s1_changed_q;
      recv_out_q <= s1_recv_q;
      loaded_q   <= s1_loaded_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign motor_duty_o     = duty_q;
  assign duty_changed_o   = changed_q;
  assign receiving_o      = recv_out_q;
  assign profile_loaded_o = loaded_q;

`ifndef NO_ASSERTIONS
  // A finished load always applies a duty and leaves receive mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && profile_loaded_o |-> duty_changed_o && !receiving_o)
    else $error("load result without duty change or still receiving");

  // Table writes happen only while receiving
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> recv_q && in_fire)
    else $error("table write outside receive mode");

  // Write index saturates at the table depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    widx_q <= WidxW'(PROFILE_POINTS))
    else $error("write index past table end");

  // Playback index stays inside the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (AddrW + 1)'(play_q) < (AddrW + 1)'(PROFILE_POINTS))
    else $error("play index past table end");

  // A word in the read stage is not dropped while results stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_addr_q))
    else $error("read stage lost a word under backpressure");
`endif

endmodule

`default_nettype wire

@@ verif/flow_profile_loader_player_tb.sv @@
// ----------------------------------------------------------------------------
// Flow profile loader/player testbench
// Drives ticks and serial text into the pump profile player and checks every
// result word against an in-bench model of the duty table, the play position
// and the token parser, over several step_ticks settings and idle patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module flow_profile_loader_player_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import flp_pkg::*;

  localparam int unsigned Points      = ProfilePointsDef;
  localparam int          QuietLimit  = 2000;  // cycles without any handshake
  localparam int          DrainCycles = 4;     // result latency plus margin
  localparam int          HoldCycles  = 150;   // long receiver hold-off
  localparam int          PhaseWords  = 80;    // live words per random phase
  localparam int          MaxReports  = 40;
  localparam int          NumPhases   = 7;
  localparam int          PressurePhase = 5;

  // step_ticks and idle pattern of each random phase; zero behaves as one,
  // and five after the slowest setting lands below the tick count
  localparam logic [15:0] PhaseStep [NumPhases] =
    '{16'd1, 16'd0, 16'd3, 16'hFFFF, 16'd5, 16'd2, 16'd40};
  localparam int PhaseTxPct [NumPhases] = '{0, 54, 0, 20, 0, 0, 20};
  localparam int PhaseRxPct [NumPhases] = '{0, 0, 54, 20, 0, 0, 20};

  typedef struct packed {
    logic [7:0] duty;
    logic       changed;
    logic       receiving;
    logic       loaded;
  } pump_out_t;

  typedef struct packed {
    logic      rt;
    logic [7:0] ch;
    logic      typed;  // want holds the result word to expect
    pump_out_t want;
  } dir_row_t;

  localparam logic Typed = 1'b1;
  localparam logic Free  = 1'b0;

  // Directed text: ignored bytes and ticks in play mode, a tick in receive
  // mode, an empty token, a signed token wrapping to 1, junk ending the
  // numeric part, NUL, a value wrapping modulo 256, then the closing '>'
  // which applies the freshly written entry 0 at once.
  localparam dir_row_t DirRows [25] = '{
    {ReqByte, CharGt,             Typed, 8'd0, 1'b0, 1'b0, 1'b0},
    {ReqByte, 8'hFF,              Typed, 8'd0, 1'b0, 1'b0, 1'b0},
    {ReqTick, 8'h00,              Typed, 8'd0, 1'b0, 1'b0, 1'b0},
    {ReqByte, CharLt,             Typed, 8'd0, 1'b0, 1'b1, 1'b0},
    {ReqTick, 8'hFF,              Typed, 8'd0, 1'b0, 1'b1, 1'b0},
    {ReqByte, CharComma,          Free,  8'd0, 1'b0, 1'b0, 1'b0},
    {ReqByte, CharTab,            Free,  8'd0, 1'b0, 1'b0, 1'b0},
    {ReqByte, CharSpace,          Free,  8'd0, 1'b0, 1'b0, 1'b0},
    {ReqByte, CharMinus,          Free,  8'd0, 1'b0, 1'b0, 1'b0},
    {ReqByte, CharZero + 8'd2,    Free,  8'd0, 1'b0, 1'b0, 1'b0},
    {ReqByte, CharZero + 8'd5,    Free,  8'd0, 1'b0, 1'b0, 1'b0},
    {ReqByte, CharZero + 8'd5,    Free,  8'd0, 1'b0, 1'b0, 1'b0},
    {ReqByte, CharComma,          Free,  8'd0, 1'b0, 1'b0, 1'b0},
    {ReqByte, CharPlus,           Free,  8'd0, 1'b0, 1'b0, 1'b0},
    {ReqByte, CharNine,           Free,  8'd0, 1'b0, 1'b0, 1'b0},
    {ReqByte, 8'h78,              Free,  8'd0, 1'b0, 1'b0, 1'b0},
    {ReqByte, CharZero + 8'd7,    Free,  8'd0, 1'b0, 1'b0, 1'b0},
    {ReqByte, CharComma,          Free,  8'd0, 1'b0, 1'b0, 1'b0},
    {ReqByte, 8'h00,              Free,  8'd0, 1'b0, 1'b0, 1'b0},
    {ReqByte, CharComma,          Free,  8'd0, 1'b0, 1'b0, 1'b0},
    {ReqByte, CharZero + 8'd3,    Free,  8'd0, 1'b0, 1'b0, 1'b0},
    {ReqByte, CharZero,           Free,  8'd0, 1'b0, 1'b0, 1'b0},
    {ReqByte, CharZero,           Free,  8'd0, 1'b0, 1'b0, 1'b0},
    {ReqByte, CharGt,             Typed, 8'd1, 1'b1, 1'b0, 1'b1},
    {ReqTick, 8'h5A,              Typed, 8'd1, 1'b0, 1'b0, 1'b0}
  };

  // DUT ports
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = StepTicksRst;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic        req_type_i  = ReqByte;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  motor_duty_o;
  logic        duty_changed_o;
  logic        receiving_o;
  logic        profile_loaded_o;

  // Pump model state
  logic [7:0]  prof_tbl [Points];
  int          play_pos;
  logic [15:0] tick_acc;
  logic        in_rx;
  int          wr_pos;
  logic [7:0]  tok_val;
  logic        tok_open;
  logic        tok_neg;
  tok_phase_e  tok_ph;
  logic [7:0]  duty_now;
  logic [15:0] step_reg;

  pump_out_t   duty_expect [$];  // result words still owed by the block
  pump_out_t   head;
  int          mismatches = 0;
  int          words_seen = 0;
  int          live_words = 0;   // words the block does not simply ignore
  int          quiet_cycles = 0;
  int          tx_pct = 0;
  int          rx_pct = 0;
  logic        hold_armed = 1'b0;
  logic        hold_taken = 1'b0;
  int          hold_left = 0;

  flow_profile_loader_player #(
    .PROFILE_POINTS(Points)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .motor_duty_o    (motor_duty_o),
    .duty_changed_o  (duty_changed_o),
    .receiving_o     (receiving_o),
    .profile_loaded_o(profile_loaded_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // round(255 * max(0, sin(2*pi*i/n))) in Q30, as the reset table holds it
  function automatic logic [7:0] sine_entry(int unsigned i, int unsigned n);
    longint unsigned dv [6];
    longint unsigned a, x, x2, acc;
    int k;
    dv = '{156, 110, 72, 42, 20, 6};
    if (n == 0 || 2 * i >= n) return 8'd0;
    a = 2 * i;
    if (n - 2 * i < a) a = n - 2 * i;
    x  = (PiQ30 * a) / n;
    x2 = (x * x) >> 30;
    acc = OneQ30;
    for (k = 0; k < 6; k++) acc = OneQ30 - (((x2 * acc) >> 30) / dv[k]);
    acc = (x * acc) >> 30;
    acc = (acc * 255 + HalfQ30) >> 30;
    return (acc > 255) ? 8'd255 : 8'(acc);
  endfunction

  function automatic void clear_token();
    tok_val  = 8'd0;
    tok_open = 1'b0;
    tok_neg  = 1'b0;
    tok_ph   = PH_SKIP;
  endfunction

  // Commit the open token to the next table entry; drop it past the end.
  function automatic void close_token();
    if (tok_open && wr_pos < Points) begin
      prof_tbl[wr_pos] = tok_neg ? -tok_val : tok_val;
      wr_pos++;
    end
    clear_token();
  endfunction

  // Advance the pump model by one input word and return its result word.
  function automatic pump_out_t pump_step(logic rt, logic [7:0] ch);
    pump_out_t r;
    logic      dig;
    r.changed = 1'b0;
    r.loaded  = 1'b0;
    dig = (ch >= CharZero) && (ch <= CharNine);
    if (rt == ReqTick) begin
      // ticks only count in play mode; a zero step acts as one
      if (!in_rx) begin
        if (int'(tick_acc) + 1 >= int'(step_reg)) begin
          tick_acc  = 16'd0;
          play_pos  = (play_pos + 1 >= Points) ? 0 : play_pos + 1;
          duty_now  = prof_tbl[play_pos];
          r.changed = 1'b1;
        end else begin
          tick_acc = tick_acc + 16'd1;
        end
      end
    end else if (!in_rx) begin
      if (ch == CharLt) begin
        in_rx  = 1'b1;
        wr_pos = 0;
        clear_token();
      end
    end else if (ch == CharGt) begin
      close_token();
      in_rx     = 1'b0;
      play_pos  = 0;
      tick_acc  = 16'd0;
      duty_now  = prof_tbl[0];
      r.changed = 1'b1;
      r.loaded  = 1'b1;
    end else if (ch == CharComma) begin
      close_token();
    end else begin
      tok_open = 1'b1;
      case (tok_ph)
        PH_SKIP: begin
          if (ch == CharSpace || (ch >= CharTab && ch <= CharCr)) begin
            // still in leading whitespace
          end else if (ch == CharPlus || ch == CharMinus) begin
            tok_neg = (ch == CharMinus);
            tok_ph  = PH_SIGN;
          end else if (dig) begin
            tok_val = ch - CharZero;
            tok_ph  = PH_DIGITS;
          end else begin
            tok_ph = PH_IGNORE;
          end
        end
        PH_SIGN: begin
          if (dig) begin
            tok_val = ch - CharZero;
            tok_ph  = PH_DIGITS;
          end else begin
            tok_ph = PH_IGNORE;
          end
        end
        PH_DIGITS: begin
          if (dig) tok_val = tok_val * 8'd10 + (ch - CharZero);
          else     tok_ph = PH_IGNORE;
        end
        default: begin
        end
      endcase
    end
    r.duty      = duty_now;
    r.receiving = in_rx;
    return r;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    if (mismatches < MaxReports)
      $display("[%0t] result word %0d, %s: got %0d, expected %0d",
               $realtime, words_seen, what, got, want);
    mismatches++;
  endtask

  // Offer one input word: idle first at random, queue its expected result,
  // then hold valid and payload until the block takes the word.
  task automatic offer_word(logic rt, logic [7:0] ch, logic typed, pump_out_t want);
    pump_out_t got;
    if (tx_pct != 0 && $urandom_range(99) < tx_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_pct);
    end
    if ((rt == ReqTick) ? !in_rx : (in_rx || ch == CharLt)) live_words++;
    got = pump_step(rt, ch);
    duty_expect.push_back(typed ? want : got);
    in_valid_i <= 1'b1;
    req_type_i <= rt;
    rx_byte_i  <= ch;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic offer_byte(logic [7:0] ch);
    offer_word(ReqByte, ch, Free, '0);
  endtask

  // the byte lane is don't-care on ticks; keep it moving anyway
  task automatic offer_tick();
    offer_word(ReqTick, 8'($urandom_range(255)), Free, '0);
  endtask

  // Drop valid, wait out every owed word, then the pipeline latency.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (duty_expect.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_step_ticks(logic [15:0] v);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    step_reg = v;
  endtask

  // a character that neither closes a token nor ends the message
  function automatic logic [7:0] token_junk();
    logic [7:0] ch;
    do ch = 8'($urandom_range(255)); while (ch == CharComma || ch == CharGt);
    return ch;
  endfunction

  // Receiver: one long hold-off when armed, otherwise stall at random.
  always @(posedge clk_i) begin
    if (hold_armed && !hold_taken) begin
      hold_taken  <= 1'b1;
      hold_left   <= HoldCycles;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !(rx_pct != 0 && $urandom_range(99) < rx_pct);
    end
  end

  // Check each accepted result word against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (duty_expect.size() == 0) begin
        flag_mismatch("no word expected", motor_duty_o, 0);
      end else begin
        head = duty_expect.pop_front();
        if (motor_duty_o !== head.duty)
          flag_mismatch("motor_duty", motor_duty_o, head.duty);
        if (duty_changed_o !== head.changed)
          flag_mismatch("duty_changed", duty_changed_o, head.changed);
        if (receiving_o !== head.receiving)
          flag_mismatch("receiving", receiving_o, head.receiving);
        if (profile_loaded_o !== head.loaded)
          flag_mismatch("profile_loaded", profile_loaded_o, head.loaded);
      end
      words_seen++;
    end
  end

  // Watchdog: end the run when no word moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("flow_profile_loader_player test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned i;
    int          p, kind, n_tok, t, n, j;
    for (i = 0; i < Points; i++) prof_tbl[i] = sine_entry(i, Points);
    play_pos = 0;
    tick_acc = 16'd0;
    in_rx    = 1'b0;
    wr_pos   = 0;
    duty_now = 8'd0;
    step_reg = StepTicksRst;
    clear_token();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed text at the reset step setting
    foreach (DirRows[r])
      offer_word(DirRows[r].rt, DirRows[r].ch, DirRows[r].typed, DirRows[r].want);

    for (p = 0; p < NumPhases; p++) begin
      // reconfigure only with the block empty
      settle_block();
      write_step_ticks(PhaseStep[p]);
      tx_pct = PhaseTxPct[p];
      rx_pct = PhaseRxPct[p];
      // fill the block behind a stalled receiver while words keep coming
      if (p == PressurePhase) hold_armed = 1'b1;
      live_words = 0;
      // open with ticks so a lowered step meets the old tick count
      repeat (3) offer_tick();

      while (live_words < PhaseWords) begin
        kind = $urandom_range(9);
        if (kind <= 4) begin
          // profile message: mostly well formed, now and then overflowing
          // the table or left without its closing '>'
          n_tok = ($urandom_range(14) == 0) ? $urandom_range(48, 58)
                                             : $urandom_range(1, 12);
          offer_byte(CharLt);
          for (t = 0; t < n_tok; t++) begin
            if (t != 0) offer_byte(CharComma);
            if ($urandom_range(19) == 0) offer_tick();
            n = $urandom_range(9);
            if (n == 1) begin
              repeat ($urandom_range(1, 3)) offer_byte(token_junk());
            end else if (n != 0) begin
              repeat ($urandom_range(0, 2)) begin
                if ($urandom_range(1) == 0) offer_byte(CharSpace);
                else offer_byte(CharTab + 8'($urandom_range(4)));
              end
              if ($urandom_range(9) < 3)
                offer_byte(($urandom_range(1) == 0) ? CharPlus : CharMinus);
              j = $urandom_range(1, 4);
              repeat (j) offer_byte(CharZero + 8'($urandom_range(9)));
              if ($urandom_range(99) < 15) offer_byte(token_junk());
            end
          end
          if ($urandom_range(9) != 0) offer_byte(CharGt);
        end else if (kind <= 7) begin
          repeat ($urandom_range(1, 25)) offer_tick();
        end else begin
          // raw noise on both request kinds
          repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(1) == 0) offer_tick();
            else offer_byte(8'($urandom_range(255)));
          end
        end
      end

      // close any open message and leave ticks counted in play mode
      if (in_rx) offer_byte(CharGt);
      repeat (12) offer_tick();
    end

    settle_block();
    if (mismatches == 0) begin
      $display("flow_profile_loader_player test passed");
    end else begin
      $display("flow_profile_loader_player test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
